### rtl/core/command_frame_crc_parser_core_defines.svh
// ----------------------------------------------------------------------------
// Command frame CRC parser: assertion macros
// Shared concurrent assertion forms, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_CRC_PARSER_CORE_DEFINES_SVH
`define COMMAND_FRAME_CRC_PARSER_CORE_DEFINES_SVH

// checked outside reset only
`define CFCP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define CFCP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/cfcp_pkg.sv
// ----------------------------------------------------------------------------
// Command frame CRC parser package
// Status codes, shared types and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package cfcp_pkg;

   localparam int unsigned COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
   localparam int unsigned PAYLOAD_FIRST = 4;
   localparam int unsigned PAYLOAD_DEPTH = 10;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_LENGTH = 3'd1;
   localparam logic [2:0] ST_HEADER = 3'd2;
   localparam logic [2:0] ST_TYPE = 3'd3;
   localparam logic [2:0] ST_CRC = 3'd4;

   localparam logic [1:0] CSR_HEAD_FIRST = 2'd0;
   localparam logic [1:0] CSR_HEAD_SECOND = 2'd1;
   localparam logic [1:0] CSR_BODY_LENGTH = 2'd2;
   localparam logic [1:0] CSR_COMMAND_TYPE = 2'd3;

   typedef struct packed {
      logic [7:0] head_first;
      logic [7:0] head_second;
      logic [7:0] body_length;
      logic [7:0] command_type;
   } cfg_type;

   typedef struct packed {
      logic       fire;
      logic [7:0] data;
      logic       last;
   } step_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         sequence_res;
      logic [7:0]         drive_mode;
      logic [7:0]         flag_bits;
      logic [7:0]         route_index;
      logic [7:0]         checkpoint_ask;
      logic [7:0]         certainty;
      logic signed [15:0] forward_speed;
      logic signed [15:0] heading;
   } result_type;

   // CRC-16/CCITT-FALSE, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

### rtl/core/cfcp_frame_track.sv
// ----------------------------------------------------------------------------
// Command frame tracker
// Per-frame state: byte count, running CRC, header/type flags, payload.
// Produces the result for the byte stepped in this cycle.
// ----------------------------------------------------------------------------
module cfcp_frame_track #(
   parameter int FRAME_BYTES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  cfcp_pkg::cfg_type    cfg,
   input  cfcp_pkg::step_type   step,
   output cfcp_pkg::result_type result
);

   localparam logic [cfcp_pkg::COUNT_W-1:0] LAST_IDX = 7'(FRAME_BYTES - 1);
   localparam logic [cfcp_pkg::COUNT_W-1:0] CRC_LOW_IDX = 7'(FRAME_BYTES - 2);
   localparam logic [cfcp_pkg::COUNT_W-1:0] CRC_END_IDX = 7'(FRAME_BYTES - 3);
   localparam logic [cfcp_pkg::COUNT_W-1:0] CRC_START_IDX = 7'd2;

   logic [cfcp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [15:0] crc_ff, crc_in;
   logic        hdr_bad_ff, hdr_bad_in;
   logic        type_bad_ff, type_bad_in;
   logic [7:0]  payload_ff [cfcp_pkg::PAYLOAD_DEPTH];
   logic [7:0]  crc_low_ff;
   logic [2:0]  status;
   logic        fields_on;

   always_comb begin
      hdr_bad_in = hdr_bad_ff;
      type_bad_in = type_bad_ff;
      crc_in = crc_ff;
      if (count_ff == 7'd0 && step.data != cfg.head_first) hdr_bad_in = 1'b1;
      if (count_ff == 7'd1 && step.data != cfg.head_second) hdr_bad_in = 1'b1;
      if (count_ff == 7'd2 && step.data != cfg.body_length) hdr_bad_in = 1'b1;
      if (count_ff == 7'd3 && step.data != cfg.command_type) type_bad_in = 1'b1;
      if (count_ff >= CRC_START_IDX && count_ff <= CRC_END_IDX) begin
         crc_in = cfcp_pkg::crc16_byte(crc_ff, step.data);
      end
      count_in = (count_ff < cfcp_pkg::COUNT_MAX) ? count_ff + 7'd1 : count_ff;
   end

   always_comb begin
      if (count_ff != LAST_IDX) begin
         status = cfcp_pkg::ST_LENGTH;
      end else if (hdr_bad_in) begin
         status = cfcp_pkg::ST_HEADER;
      end else if (type_bad_in) begin
         status = cfcp_pkg::ST_TYPE;
      end else if ({step.data, crc_low_ff} != crc_in) begin
         status = cfcp_pkg::ST_CRC;
      end else begin
         status = cfcp_pkg::ST_OK;
      end
      fields_on = (status == cfcp_pkg::ST_OK);
      result.status = status;
      result.sequence_res = fields_on ? payload_ff[0] : 8'd0;
      result.drive_mode = fields_on ? payload_ff[1] : 8'd0;
      result.flag_bits = fields_on ? payload_ff[2] : 8'd0;
      result.route_index = fields_on ? payload_ff[3] : 8'd0;
      result.checkpoint_ask = fields_on ? payload_ff[4] : 8'd0;
      result.certainty = fields_on ? payload_ff[5] : 8'd0;
      result.forward_speed = fields_on ? {payload_ff[7], payload_ff[6]} : 16'd0;
      result.heading = fields_on ? {payload_ff[9], payload_ff[8]} : 16'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff <= cfcp_pkg::CRC_INIT;
         hdr_bad_ff <= 1'b0;
         type_bad_ff <= 1'b0;
      end else if (step.fire) begin
         if (step.last) begin
            count_ff <= '0;
            crc_ff <= cfcp_pkg::CRC_INIT;
            hdr_bad_ff <= 1'b0;
            type_bad_ff <= 1'b0;
         end else begin
            count_ff <= count_in;
            crc_ff <= crc_in;
            hdr_bad_ff <= hdr_bad_in;
            type_bad_ff <= type_bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step.fire) begin
         for (int i = 0; i < cfcp_pkg::PAYLOAD_DEPTH; i++) begin
            if (count_ff == 7'(cfcp_pkg::PAYLOAD_FIRST + i)) payload_ff[i] <= step.data;
         end
         if (count_ff == CRC_LOW_IDX) crc_low_ff <= step.data;
      end
   end

endmodule

### rtl/core/command_frame_crc_parser_core.sv
// ----------------------------------------------------------------------------
// Command frame CRC parser core
// Checks a byte-serial command frame and decodes its payload fields.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one frame byte per item; req_tlast marks the last byte of a buffer.
//   rsp_*  : one result item per buffer, issued for the byte carrying req_tlast.
//   csr_*  : expected head bytes, body length and type; write only while idle.
// Timing:
//   A byte is held in the input register, then the frame tracker updates
//   its state and the result register loads; rsp_tvalid rises as it loads.
//   Throughput is one byte per cycle unless a final byte waits on a pending
//   result, set by the combinational CRC byte update in the tracker.
// Stall:
//   A pending result holds in the output register. Non-final bytes keep flowing;
//   a final byte waits in the input register until the result is taken, and
//   req_tready drops only then.
// Reset:
//   Clears both registers' valid flags, the frame state and the csr registers.
// ----------------------------------------------------------------------------
`include "command_frame_crc_parser_core_defines.svh"

module command_frame_crc_parser_core #(
   parameter int FRAME_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // status[2:0], sequence_res, drive_mode, flag_bits,
                                    // route_index, checkpoint_ask, certainty,
                                    // forward_speed[16], heading[16], zero fill
   input  logic        csr_wen,
   input  logic [1:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   cfcp_pkg::cfg_type    cfg_ff;
   cfcp_pkg::step_type   step;
   cfcp_pkg::result_type result;
   cfcp_pkg::result_type out_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wen) begin
         case (csr_addr)
            cfcp_pkg::CSR_HEAD_FIRST: cfg_ff.head_first <= csr_wdata;
            cfcp_pkg::CSR_HEAD_SECOND: cfg_ff.head_second <= csr_wdata;
            cfcp_pkg::CSR_BODY_LENGTH: cfg_ff.body_length <= csr_wdata;
            cfcp_pkg::CSR_COMMAND_TYPE: cfg_ff.command_type <= csr_wdata;
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign advance = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign out_load = advance && in_last_ff;
   assign req_tready = !in_valid_ff || advance;

   assign step.fire = advance;
   assign step.data = in_data_ff;
   assign step.last = in_last_ff;

   cfcp_frame_track #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_track (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .step  (step),
      .result(result)
   );

   always_comb begin
      in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (out_load) out_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'd0, out_ff.heading, out_ff.forward_speed, out_ff.certainty,
                       out_ff.checkpoint_ask, out_ff.route_index, out_ff.flag_bits,
                       out_ff.drive_mode, out_ff.sequence_res, out_ff.status};

   `CFCP_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_tvalid,
      "result valid right after reset")
   `CFCP_ASSERT(a_status_range, rsp_tvalid |-> out_ff.status <= cfcp_pkg::ST_CRC,
      "status code out of range")
   `CFCP_ASSERT(a_fields_zero,
      rsp_tvalid && out_ff.status != cfcp_pkg::ST_OK |-> rsp_tdata[87:3] == '0,
      "fields not zero on error status")
   `CFCP_ASSERT(a_empty_ready, !in_valid_ff |-> req_tready,
      "input register empty but not ready")
   `CFCP_ASSERT(a_body_flows, in_valid_ff && !in_last_ff |-> advance,
      "non-final item stalled")

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame CRC parser testbench
// Sends byte-serial command frames into the parser and compares every result
// item with a local frame tracker. A short table of directed frames covers the
// register extremes, each status code and the check priority. Random frames
// follow, mostly well formed with random payload, the rest broken or noise.
// Random gaps are applied on both channels, plus one long result hold-off.
// ----------------------------------------------------------------------------
module tb;

   localparam int FRAME_LEN = 16;
   localparam int NO_FLIP = -1;
   localparam int WANT_MODEL = -1;
   localparam int WANT_OK = int'(cfcp_pkg::ST_OK);
   localparam int WANT_LENGTH = int'(cfcp_pkg::ST_LENGTH);
   localparam int WANT_HEADER = int'(cfcp_pkg::ST_HEADER);
   localparam int WANT_TYPE = int'(cfcp_pkg::ST_TYPE);
   localparam int WANT_CRC = int'(cfcp_pkg::ST_CRC);
   localparam int RAND_ITEMS = 130;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 12;

   typedef enum int {PAY_ZERO, PAY_ONES, PAY_RAND, PAY_MIN, PAY_MAX, PAY_NOISE} pay_kind_type;

   typedef struct {
      bit                cfg_en;
      cfcp_pkg::cfg_type cfg;
      int                len;
      pay_kind_type      pay;
      int                fa;
      logic [7:0]        ma;
      int                fb;
      logic [7:0]        mb;
      int                want;
   } frame_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;    // frame_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;           // status, sequence_res, drive_mode, flag_bits,
                                     // route_index, checkpoint_ask, certainty,
                                     // forward_speed, heading, zero fill
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_addr = 2'd0;
   logic [7:0]  csr_wdata = 8'h00;

   // frame tracker
   cfcp_pkg::cfg_type    cfg_model;
   logic [6:0]           trk_count;
   logic [15:0]          trk_crc;
   logic                 trk_head_bad;
   logic                 trk_type_bad;
   logic [7:0]           trk_payload [cfcp_pkg::PAYLOAD_DEPTH];
   logic [7:0]           trk_crc_lo;
   cfcp_pkg::result_type pending_results [$];

   frame_row_type    frame_table [$];
   logic [7:0]       frame_buf [0:159];
   int               frame_len;

   int               items_sent = 0;
   int               tx_quiet = 0;
   int               rx_quiet = 0;
   int               rx_stall = 0;
   int               hold_count = 0;
   bit               pressure_go = 1'b0;
   bit               pressure_done = 1'b0;
   bit               failed = 1'b0;

   command_frame_crc_parser_core #(.FRAME_BYTES(FRAME_LEN)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("command_frame_crc_parser_core: mismatch");
      $finish;
   end

   // bitwise CRC-16/CCITT-FALSE step, MSB first
   function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ b[i];
         r = {r[14:0], 1'b0} ^ (fb ? cfcp_pkg::CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic int next_gap(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 63) == 0) begin
         quiet = $urandom_range(40, 150);
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic cfcp_pkg::result_type decode_rsp(input logic [87:0] d);
      cfcp_pkg::result_type r;
      r.status = d[2:0];
      r.sequence_res = d[10:3];
      r.drive_mode = d[18:11];
      r.flag_bits = d[26:19];
      r.route_index = d[34:27];
      r.checkpoint_ask = d[42:35];
      r.certainty = d[50:43];
      r.forward_speed = d[66:51];
      r.heading = d[82:67];
      return r;
   endfunction

   task automatic clear_tracker();
      trk_count = '0;
      trk_crc = cfcp_pkg::CRC_INIT;
      trk_head_bad = 1'b0;
      trk_type_bad = 1'b0;
   endtask

   task automatic track_byte(input logic [7:0] b, input logic last, input int want);
      int                   idx;
      cfcp_pkg::result_type r;
      idx = int'(trk_count);
      if (idx == 0 && b != cfg_model.head_first) trk_head_bad = 1'b1;
      if (idx == 1 && b != cfg_model.head_second) trk_head_bad = 1'b1;
      if (idx == 2 && b != cfg_model.body_length) trk_head_bad = 1'b1;
      if (idx == 3 && b != cfg_model.command_type) trk_type_bad = 1'b1;
      if (idx >= 2 && idx <= FRAME_LEN - 3) trk_crc = crc_update(trk_crc, b);
      if (idx >= cfcp_pkg::PAYLOAD_FIRST &&
          idx < cfcp_pkg::PAYLOAD_FIRST + cfcp_pkg::PAYLOAD_DEPTH)
         trk_payload[idx - cfcp_pkg::PAYLOAD_FIRST] = b;
      if (idx == FRAME_LEN - 2) trk_crc_lo = b;
      if (trk_count != cfcp_pkg::COUNT_MAX) trk_count = trk_count + 7'd1;
      if (last) begin
         r = '0;
         if (idx + 1 != FRAME_LEN) r.status = cfcp_pkg::ST_LENGTH;
         else if (trk_head_bad) r.status = cfcp_pkg::ST_HEADER;
         else if (trk_type_bad) r.status = cfcp_pkg::ST_TYPE;
         else if ({b, trk_crc_lo} != trk_crc) r.status = cfcp_pkg::ST_CRC;
         else r.status = cfcp_pkg::ST_OK;
         if (r.status == cfcp_pkg::ST_OK) begin
            r.sequence_res = trk_payload[0];
            r.drive_mode = trk_payload[1];
            r.flag_bits = trk_payload[2];
            r.route_index = trk_payload[3];
            r.checkpoint_ask = trk_payload[4];
            r.certainty = trk_payload[5];
            r.forward_speed = {trk_payload[7], trk_payload[6]};
            r.heading = {trk_payload[9], trk_payload[8]};
         end
         if (want != WANT_MODEL) begin
            r = '0;
            r.status = want[2:0];
         end
         pending_results.push_back(r);
         clear_tracker();
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
      if (e !== a) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, e, a);
         failed = 1'b1;
      end
   endtask

   task automatic check_result();
      cfcp_pkg::result_type e;
      cfcp_pkg::result_type a;
      a = decode_rsp(rsp_tdata);
      if (pending_results.size() == 0) begin
         $error("result item with no expectation: status 0x%0h", a.status);
         failed = 1'b1;
      end else begin
         e = pending_results.pop_front();
         check_field("status", 16'(e.status), 16'(a.status));
         check_field("sequence_res", 16'(e.sequence_res), 16'(a.sequence_res));
         check_field("drive_mode", 16'(e.drive_mode), 16'(a.drive_mode));
         check_field("flag_bits", 16'(e.flag_bits), 16'(a.flag_bits));
         check_field("route_index", 16'(e.route_index), 16'(a.route_index));
         check_field("checkpoint_ask", 16'(e.checkpoint_ask), 16'(a.checkpoint_ask));
         check_field("certainty", 16'(e.certainty), 16'(a.certainty));
         check_field("forward_speed", e.forward_speed, a.forward_speed);
         check_field("heading", e.heading, a.heading);
      end
   endtask

   // result side: check, then pick next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (pressure_go && !pressure_done) begin
            rsp_tready <= 1'b0;
            if (hold_count == HOLD_CYCLES) pressure_done = 1'b1;
            else hold_count++;
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rx_stall = next_gap(rx_quiet);
            if (rx_stall == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               rx_stall--;
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] d, input logic l, input int want);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= l;
      do @(posedge clock); while (!req_tready);
      track_byte(d, l, want);
      items_sent++;
      gap = next_gap(tx_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic make_frame(input int len, input pay_kind_type pay, input int fa,
                             input logic [7:0] ma, input int fb, input logic [7:0] mb);
      logic [15:0] c;
      frame_buf[0] = cfg_model.head_first;
      frame_buf[1] = cfg_model.head_second;
      frame_buf[2] = cfg_model.body_length;
      frame_buf[3] = cfg_model.command_type;
      for (int i = cfcp_pkg::PAYLOAD_FIRST;
           i < cfcp_pkg::PAYLOAD_FIRST + cfcp_pkg::PAYLOAD_DEPTH; i++) begin
         case (pay)
            PAY_ZERO: frame_buf[i] = 8'h00;
            PAY_ONES: frame_buf[i] = 8'hFF;
            PAY_MIN:  frame_buf[i] = (i == 11 || i == 13) ? 8'h80 : 8'h00;
            PAY_MAX:  frame_buf[i] = (i == 10 || i == 12) ? 8'hFF : 8'h7F;
            default:  frame_buf[i] = 8'($urandom);
         endcase
      end
      c = cfcp_pkg::CRC_INIT;
      for (int i = 2; i <= FRAME_LEN - 3; i++) c = crc_update(c, frame_buf[i]);
      frame_buf[FRAME_LEN - 2] = c[7:0];
      frame_buf[FRAME_LEN - 1] = c[15:8];
      for (int i = FRAME_LEN; i < len; i++) frame_buf[i] = 8'($urandom);
      if (pay == PAY_NOISE)
         for (int i = 0; i < len; i++) frame_buf[i] = 8'($urandom);
      if (fa >= 0 && fa < len) frame_buf[fa] = frame_buf[fa] ^ ma;
      if (fb >= 0 && fb < len) frame_buf[fb] = frame_buf[fb] ^ mb;
      frame_len = len;
   endtask

   task automatic send_frame(input int want);
      for (int i = 0; i < frame_len; i++)
         push_byte(frame_buf[i], (i == frame_len - 1), want);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input cfcp_pkg::cfg_type c);
      csr_wen <= 1'b1;
      csr_addr <= cfcp_pkg::CSR_HEAD_FIRST;
      csr_wdata <= c.head_first;
      @(posedge clock);
      csr_addr <= cfcp_pkg::CSR_HEAD_SECOND;
      csr_wdata <= c.head_second;
      @(posedge clock);
      csr_addr <= cfcp_pkg::CSR_BODY_LENGTH;
      csr_wdata <= c.body_length;
      @(posedge clock);
      csr_addr <= cfcp_pkg::CSR_COMMAND_TYPE;
      csr_wdata <= c.command_type;
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_model = c;
   endtask

   task automatic add_row(input bit cfg_en, input cfcp_pkg::cfg_type cfg, input int len,
                          input pay_kind_type pay, input int fa, input logic [7:0] ma,
                          input int fb, input logic [7:0] mb, input int want);
      frame_row_type row;
      row.cfg_en = cfg_en;
      row.cfg = cfg;
      row.len = len;
      row.pay = pay;
      row.fa = fa;
      row.ma = ma;
      row.fb = fb;
      row.mb = mb;
      row.want = want;
      frame_table.push_back(row);
   endtask

   initial begin
      frame_row_type     row;
      int                start_items;
      int                frames;
      int                pick;
      int                len;
      int                fa;
      logic [7:0]        ma;
      pay_kind_type      pay;
      cfcp_pkg::cfg_type c;

      //      cfg   value         len  payload    flip a       flip b        want
      add_row(0, 32'h00000000, 16, PAY_ZERO, NO_FLIP, 8'h00, NO_FLIP, 8'h00, WANT_OK);
      add_row(1, 32'hFFFFFFFF, 16, PAY_ONES, NO_FLIP, 8'h00, NO_FLIP, 8'h00, WANT_MODEL);
      add_row(0, 32'h00000000, 1,  PAY_RAND, NO_FLIP, 8'h00, NO_FLIP, 8'h00, WANT_LENGTH);
      add_row(0, 32'h00000000, 15, PAY_RAND, 0,       8'h01, NO_FLIP, 8'h00, WANT_LENGTH);
      add_row(0, 32'h00000000, 17, PAY_RAND, NO_FLIP, 8'h00, NO_FLIP, 8'h00, WANT_LENGTH);
      add_row(0, 32'h00000000, 130, PAY_RAND, NO_FLIP, 8'h00, NO_FLIP, 8'h00, WANT_LENGTH);
      add_row(1, 32'hA55A0C01, 16, PAY_RAND, NO_FLIP, 8'h00, NO_FLIP, 8'h00, WANT_MODEL);
      add_row(0, 32'h00000000, 16, PAY_RAND, 0,       8'h01, NO_FLIP, 8'h00, WANT_HEADER);
      add_row(0, 32'h00000000, 16, PAY_RAND, 1,       8'h80, NO_FLIP, 8'h00, WANT_HEADER);
      add_row(0, 32'h00000000, 16, PAY_RAND, 2,       8'hFF, NO_FLIP, 8'h00, WANT_HEADER);
      add_row(0, 32'h00000000, 16, PAY_RAND, 3,       8'h10, NO_FLIP, 8'h00, WANT_TYPE);
      add_row(0, 32'h00000000, 16, PAY_RAND, 0,       8'h40, 3,       8'h02, WANT_HEADER);
      add_row(0, 32'h00000000, 16, PAY_RAND, 3,       8'h01, 14,      8'h01, WANT_TYPE);
      add_row(0, 32'h00000000, 16, PAY_RAND, 14,      8'h01, NO_FLIP, 8'h00, WANT_CRC);
      add_row(0, 32'h00000000, 16, PAY_RAND, 15,      8'h80, NO_FLIP, 8'h00, WANT_CRC);
      add_row(0, 32'h00000000, 16, PAY_RAND, 9,       8'h04, NO_FLIP, 8'h00, WANT_CRC);
      add_row(0, 32'h00000000, 16, PAY_MIN,  NO_FLIP, 8'h00, NO_FLIP, 8'h00, WANT_MODEL);
      add_row(0, 32'h00000000, 16, PAY_MAX,  NO_FLIP, 8'h00, NO_FLIP, 8'h00, WANT_MODEL);
      add_row(1, 32'h00000000, 14, PAY_RAND, NO_FLIP, 8'h00, NO_FLIP, 8'h00, WANT_LENGTH);
      add_row(0, 32'h00000000, 16, PAY_RAND, NO_FLIP, 8'h00, NO_FLIP, 8'h00, WANT_MODEL);

      cfg_model = '0;
      clear_tracker();
      for (int i = 0; i < cfcp_pkg::PAYLOAD_DEPTH; i++) trk_payload[i] = 8'h00;
      trk_crc_lo = 8'h00;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (frame_table[i]) begin
         row = frame_table[i];
         if (row.cfg_en) begin
            wait_drain();
            load_config(row.cfg);
         end
         make_frame(row.len, row.pay, row.fa, row.ma, row.fb, row.mb);
         send_frame(row.want);
      end

      wait_drain();
      load_config(cfcp_pkg::cfg_type'($urandom));
      pressure_go <= 1'b1;
      start_items = items_sent;
      frames = 0;
      while ((items_sent - start_items) < RAND_ITEMS) begin
         if (frames != 0 && frames % 8 == 0) begin
            wait_drain();
            pick = $urandom_range(0, 5);
            if (pick == 0) c = 32'h00000000;
            else if (pick == 1) c = 32'hFFFFFFFF;
            else c = cfcp_pkg::cfg_type'($urandom);
            load_config(c);
         end
         pick = $urandom_range(0, 99);
         len = FRAME_LEN;
         fa = NO_FLIP;
         ma = 8'($urandom_range(1, 255));
         pay = ($urandom_range(0, 9) == 0) ? pay_kind_type'($urandom_range(0, 4)) : PAY_RAND;
         if (pick < 55) begin
            fa = NO_FLIP;
         end else if (pick < 63) begin
            fa = $urandom_range(0, 2);
         end else if (pick < 70) begin
            fa = 3;
         end else if (pick < 78) begin
            fa = $urandom_range(cfcp_pkg::PAYLOAD_FIRST, FRAME_LEN - 1);
         end else if (pick < 92) begin
            if ($urandom_range(0, 19) == 0) len = $urandom_range(120, 140);
            else len = $urandom_range(1, 31);
            if (len == FRAME_LEN) len = FRAME_LEN + 1;
         end else begin
            pay = PAY_NOISE;
            len = $urandom_range(1, 20);
         end
         make_frame(len, pay, fa, ma, NO_FLIP, 8'h00);
         send_frame(WANT_MODEL);
         frames++;
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (!failed && pending_results.size() == 0) begin
         $display("command_frame_crc_parser_core: match");
      end else begin
         $display("command_frame_crc_parser_core: mismatch");
      end
      $finish;
   end

endmodule
